// ----- rtl/pfa_pkg.sv -----
package pfa_pkg;

  localparam int COORD_W        = 16;
  localparam int COORD_BITS_DEF = 16;
  localparam int AREA_W         = 35;
  localparam int VTX_DEPTH      = 4;
  localparam int VTX_AW         = $clog2(VTX_DEPTH);
  localparam int VCNT_W         = $clog2(VTX_DEPTH + 1);

  typedef struct packed {
    logic [VCNT_W-1:0] cnt;
    logic              ovf;
  } vs_stat_t;

endpackage

// ----- rtl/pfa_vstore.sv -----
module pfa_vstore #(
  parameter int COORD_BITS = pfa_pkg::COORD_BITS_DEF
) (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        wr_en_i,
  input  logic                        close_i,
  input  logic [3*COORD_BITS-1:0]     wr_data_i,
  input  logic [pfa_pkg::VTX_AW-1:0]  rd_addr_i,
  output logic [3*COORD_BITS-1:0]     rd_data_o,
  output pfa_pkg::vs_stat_t           stat_o
);
  import pfa_pkg::*;

  localparam logic [VCNT_W-1:0] CntFull = VCNT_W'(VTX_DEPTH);

  logic [3*COORD_BITS-1:0] mem_q [VTX_DEPTH];
  logic [3*COORD_BITS-1:0] rd_data_q;
  logic [VCNT_W-1:0]       cnt_q;
  logic                    ovf_q;
  logic                    full;

  assign full = (cnt_q == CntFull);

  always_ff @(posedge clk_i) begin
    if (wr_en_i && !full) begin
      mem_q[cnt_q[VTX_AW-1:0]] <= wr_data_i;
    end
    rd_data_q <= mem_q[rd_addr_i];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q <= '0;
      ovf_q <= 1'b0;
    end else if (close_i) begin
      cnt_q <= '0;
      ovf_q <= 1'b0;
    end else if (wr_en_i) begin
      if (full) begin
        ovf_q <= 1'b1;
      end else begin
        cnt_q <= cnt_q + VCNT_W'(1);
      end
    end
  end

  assign rd_data_o  = rd_data_q;
  assign stat_o.cnt = cnt_q;
  assign stat_o.ovf = ovf_q;

endmodule

// ----- rtl/pfa_mul.sv -----
module pfa_mul #(
  parameter int OP_W = pfa_pkg::COORD_BITS_DEF + 2
) (
  input  logic                     clk_i,
  input  logic signed [OP_W-1:0]   a_i,
  input  logic signed [OP_W-1:0]   b_i,
  output logic signed [2*OP_W-1:0] prod_o
);
  import pfa_pkg::*;

  logic signed [2*OP_W-1:0] prod_q;

  always_ff @(posedge clk_i) begin
    prod_q <= a_i * b_i;
  end

  assign prod_o = prod_q;

endmodule

// ----- rtl/pfa_isqrt.sv -----
module pfa_isqrt #(
  parameter int RAD_W = 4 * (pfa_pkg::COORD_BITS_DEF + 1)
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               start_i,
  input  logic [RAD_W-1:0]   rad_i,
  output logic               done_o,
  output logic [RAD_W/2-1:0] root_o
);
  import pfa_pkg::*;

  localparam int RT_W  = RAD_W / 2;
  localparam int RM_W  = RT_W + 2;
  localparam int CNT_W = $clog2(RT_W + 1);

  logic [RAD_W-1:0] rad_q;
  logic [RM_W-1:0]  rem_q, rem_d, rem_sh, trial;
  logic [RT_W-1:0]  root_q, root_d;
  logic [CNT_W-1:0] cnt_q;
  logic             done_q;
  logic             ge;

  // two radicand bits per step
  always_comb begin
    rem_sh = {rem_q[RM_W-3:0], rad_q[RAD_W-1 -: 2]};
    trial  = RM_W'({root_q[RT_W-2:0], 2'b01});
    ge     = (rem_sh >= trial);
    rem_d  = ge ? (rem_sh - trial) : rem_sh;
    root_d = {root_q[RT_W-2:0], ge};
  end

  always_ff @(posedge clk_i) begin
    if (start_i) begin
      rad_q  <= rad_i;
      rem_q  <= '0;
      root_q <= '0;
    end else if (cnt_q != '0) begin
      rad_q  <= {rad_q[RAD_W-3:0], 2'b00};
      rem_q  <= rem_d;
      root_q <= root_d;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q  <= '0;
      done_q <= 1'b0;
    end else begin
      done_q <= 1'b0;
      if (start_i) begin
        cnt_q <= CNT_W'(RT_W);
      end else if (cnt_q != '0) begin
        cnt_q <= cnt_q - CNT_W'(1);
        if (cnt_q == CNT_W'(1)) begin
          done_q <= 1'b1;
        end
      end
    end
  end

  assign done_o = done_q;
  assign root_o = root_q;

endmodule

// ----- rtl/polygon_face_area.sv -----
// Channel   Handshake            Payload
// vertex    start / busy         coord_x_i, coord_y_i, coord_z_i, last_i
// result    done_o (one cycle)   twice_area_o, bad_count_o
//
// A face closed with a bad vertex count gives its result in the next cycle. A
// good face runs through the load, cross, square and root steps once per
// triangle (one triangle or two), using the shared multiplier and the
// two-bit-per-cycle square-root unit; busy is high meanwhile. Reset clears
// the vertex count. The receiver cannot stall: done_o marks one cycle only.
module polygon_face_area #(
  parameter int COORD_BITS = pfa_pkg::COORD_BITS_DEF
) (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        start,
  output logic                        busy,
  input  logic [pfa_pkg::COORD_W-1:0] coord_x_i,
  input  logic [pfa_pkg::COORD_W-1:0] coord_y_i,
  input  logic [pfa_pkg::COORD_W-1:0] coord_z_i,
  input  logic                        last_i,
  output logic                        done_o,
  output logic [pfa_pkg::AREA_W-1:0]  twice_area_o,
  output logic                        bad_count_o
);
  import pfa_pkg::*;

  localparam int C   = COORD_BITS;
  localparam int EW  = C + 1;
  localparam int H   = C + 1;
  localparam int MOW = H + 1;
  localparam int PW  = 2 * MOW;
  localparam int MW  = 2 * H;
  localparam int RW  = 4 * H;
  localparam int RTW = 2 * H;

  localparam logic [3:0] LoadLast  = 4'd3;
  localparam logic [3:0] CrossLast = 4'd6;
  localparam logic [3:0] SqLast    = 4'd9;

  typedef enum logic [2:0] {
    ST_IDLE, ST_LOAD, ST_CROSS, ST_SQUARE, ST_ROOT
  } state_e;

  typedef enum logic [1:0] {
    PART_HH, PART_HL, PART_LL
  } part_e;

  state_e state_q;
  logic [3:0] step_q;
  logic       tri_q, quad_q, done_q, bad_q;
  logic [AREA_W-1:0] area_q, area_out_q, area_d;

  logic       accept, face_bad, face_quad;
  vs_stat_t   vs_stat;
  logic [VTX_AW-1:0] rd_addr;
  logic [3*C-1:0]    rd_data;

  logic signed [C-1:0]  rd_x, rd_y, rd_z, p0x_q, p0y_q, p0z_q;
  logic signed [EW-1:0] ex, ey, ez;
  logic signed [EW-1:0] ax_q, ay_q, az_q, bx_q, by_q, bz_q;
  logic signed [MOW-1:0] mul_a, mul_b;
  logic signed [PW-1:0]  prod, acc_q, diff, diff_abs;
  logic [MW-1:0]  cx_q, cy_q, cz_q, c_sel;
  part_e          part, tag_q;
  logic [RW-1:0]  sum_q, sum_d, term;
  logic [2*H-1:0] pu;
  logic           sq_start, sq_done;
  logic [RTW-1:0] root;

  assign accept    = start && !busy;
  assign face_bad  = vs_stat.ovf || (vs_stat.cnt == VCNT_W'(VTX_DEPTH)) ||
                     (vs_stat.cnt < VCNT_W'(2));
  assign face_quad = (vs_stat.cnt == VCNT_W'(3));

  // triangles 0-1-2 and 2-3-0
  always_comb begin
    rd_addr = '0;
    unique case (step_q[1:0])
      2'd0:    rd_addr = tri_q ? VTX_AW'(2) : VTX_AW'(0);
      2'd1:    rd_addr = tri_q ? VTX_AW'(3) : VTX_AW'(1);
      2'd2:    rd_addr = tri_q ? VTX_AW'(0) : VTX_AW'(2);
      default: rd_addr = '0;
    endcase
  end

  pfa_vstore #(.COORD_BITS(C)) u_vstore (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .wr_en_i   (accept),
    .close_i   (accept && last_i),
    .wr_data_i ({coord_x_i[C-1:0], coord_y_i[C-1:0], coord_z_i[C-1:0]}),
    .rd_addr_i (rd_addr),
    .rd_data_o (rd_data),
    .stat_o    (vs_stat)
  );

  always_comb begin
    rd_x = rd_data[3*C-1:2*C];
    rd_y = rd_data[2*C-1:C];
    rd_z = rd_data[C-1:0];
    ex   = $signed({rd_x[C-1], rd_x}) - $signed({p0x_q[C-1], p0x_q});
    ey   = $signed({rd_y[C-1], rd_y}) - $signed({p0y_q[C-1], p0y_q});
    ez   = $signed({rd_z[C-1], rd_z}) - $signed({p0z_q[C-1], p0z_q});
  end

  // operand selection for the shared multiplier
  always_comb begin
    mul_a = '0;
    mul_b = '0;
    c_sel = cx_q;
    part  = PART_HH;
    if (state_q == ST_CROSS) begin
      unique case (step_q)
        4'd0:    begin mul_a = {ay_q[EW-1], ay_q}; mul_b = {bz_q[EW-1], bz_q}; end
        4'd1:    begin mul_a = {az_q[EW-1], az_q}; mul_b = {by_q[EW-1], by_q}; end
        4'd2:    begin mul_a = {az_q[EW-1], az_q}; mul_b = {bx_q[EW-1], bx_q}; end
        4'd3:    begin mul_a = {ax_q[EW-1], ax_q}; mul_b = {bz_q[EW-1], bz_q}; end
        4'd4:    begin mul_a = {ax_q[EW-1], ax_q}; mul_b = {by_q[EW-1], by_q}; end
        4'd5:    begin mul_a = {ay_q[EW-1], ay_q}; mul_b = {bx_q[EW-1], bx_q}; end
        default: begin mul_a = '0; mul_b = '0; end
      endcase
    end else if (state_q == ST_SQUARE) begin
      unique case (step_q)
        4'd0:    begin c_sel = cx_q; part = PART_HH; end
        4'd1:    begin c_sel = cx_q; part = PART_HL; end
        4'd2:    begin c_sel = cx_q; part = PART_LL; end
        4'd3:    begin c_sel = cy_q; part = PART_HH; end
        4'd4:    begin c_sel = cy_q; part = PART_HL; end
        4'd5:    begin c_sel = cy_q; part = PART_LL; end
        4'd6:    begin c_sel = cz_q; part = PART_HH; end
        4'd7:    begin c_sel = cz_q; part = PART_HL; end
        4'd8:    begin c_sel = cz_q; part = PART_LL; end
        default: begin c_sel = cx_q; part = PART_HH; end
      endcase
      unique case (part)
        PART_HH: begin mul_a = {1'b0, c_sel[MW-1:H]}; mul_b = {1'b0, c_sel[MW-1:H]}; end
        PART_HL: begin mul_a = {1'b0, c_sel[MW-1:H]}; mul_b = {1'b0, c_sel[H-1:0]}; end
        PART_LL: begin mul_a = {1'b0, c_sel[H-1:0]};  mul_b = {1'b0, c_sel[H-1:0]}; end
        default: begin mul_a = '0; mul_b = '0; end
      endcase
    end
  end

  pfa_mul #(.OP_W(MOW)) u_mul (
    .clk_i  (clk_i),
    .a_i    (mul_a),
    .b_i    (mul_b),
    .prod_o (prod)
  );

  always_comb begin
    diff     = acc_q - prod;
    diff_abs = diff[PW-1] ? -diff : diff;
    pu       = prod[2*H-1:0];
    unique case (tag_q)
      PART_HH: term = {pu, {(2*H){1'b0}}};
      PART_HL: term = RW'(pu) << (H + 1);
      PART_LL: term = RW'(pu);
      default: term = '0;
    endcase
    sum_d    = sum_q + term;
    area_d   = area_q + AREA_W'(root);
  end

  assign sq_start = (state_q == ST_SQUARE) && (step_q == SqLast);

  pfa_isqrt #(.RAD_W(RW)) u_isqrt (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (sq_start),
    .rad_i   (sum_d),
    .done_o  (sq_done),
    .root_o  (root)
  );

  // datapath registers
  always_ff @(posedge clk_i) begin
    tag_q <= part;
    if (state_q == ST_LOAD) begin
      unique case (step_q)
        4'd1:    begin p0x_q <= rd_x; p0y_q <= rd_y; p0z_q <= rd_z; end
        4'd2:    begin ax_q <= ex; ay_q <= ey; az_q <= ez; end
        4'd3:    begin bx_q <= ex; by_q <= ey; bz_q <= ez; end
        default: ;
      endcase
    end
    if (state_q == ST_CROSS && step_q != 4'd0) begin
      if (step_q[0]) begin
        acc_q <= prod;
      end else begin
        unique case (step_q)
          4'd2:    cx_q <= diff_abs[MW-1:0];
          4'd4:    cy_q <= diff_abs[MW-1:0];
          default: cz_q <= diff_abs[MW-1:0];
        endcase
      end
      if (step_q == CrossLast) begin
        sum_q <= '0;
      end
    end
    if (state_q == ST_SQUARE && step_q != 4'd0) begin
      sum_q <= sum_d;
    end
  end

  // sequencer
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q    <= ST_IDLE;
      step_q     <= '0;
      tri_q      <= 1'b0;
      quad_q     <= 1'b0;
      done_q     <= 1'b0;
      bad_q      <= 1'b0;
      area_q     <= '0;
      area_out_q <= '0;
    end else begin
      done_q <= 1'b0;
      unique case (state_q)
        ST_IDLE: begin
          if (accept && last_i) begin
            if (face_bad) begin
              done_q     <= 1'b1;
              bad_q      <= 1'b1;
              area_out_q <= '0;
            end else begin
              state_q <= ST_LOAD;
              step_q  <= '0;
              tri_q   <= 1'b0;
              quad_q  <= face_quad;
              area_q  <= '0;
            end
          end
        end
        ST_LOAD: begin
          if (step_q == LoadLast) begin
            state_q <= ST_CROSS;
            step_q  <= '0;
          end else begin
            step_q <= step_q + 4'd1;
          end
        end
        ST_CROSS: begin
          if (step_q == CrossLast) begin
            state_q <= ST_SQUARE;
            step_q  <= '0;
          end else begin
            step_q <= step_q + 4'd1;
          end
        end
        ST_SQUARE: begin
          if (step_q == SqLast) begin
            state_q <= ST_ROOT;
            step_q  <= '0;
          end else begin
            step_q <= step_q + 4'd1;
          end
        end
        ST_ROOT: begin
          if (sq_done) begin
            area_q <= area_d;
            if (quad_q && !tri_q) begin
              tri_q   <= 1'b1;
              state_q <= ST_LOAD;
              step_q  <= '0;
            end else begin
              done_q     <= 1'b1;
              bad_q      <= 1'b0;
              area_out_q <= area_d;
              state_q    <= ST_IDLE;
            end
          end
        end
        default: state_q <= ST_IDLE;
      endcase
    end
  end

  assign busy         = (state_q != ST_IDLE);
  assign done_o       = done_q;
  assign twice_area_o = area_out_q;
  assign bad_count_o  = bad_q;

endmodule
